FILE: design/vrrp_advert_checker_top_defines.svh
`ifndef VRRP_ADVERT_CHECKER_TOP_DEFINES_SVH
`define VRRP_ADVERT_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication on clk, quiet while arst_n is low
`define VAC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vrrp advert checker: same-cycle property failed");

// Next-cycle implication on clk, quiet while arst_n is low
`define VAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vrrp advert checker: next-cycle property failed");

`endif

FILE: design/vac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vac_pkg;

	// Byte counter width and the width reported on packet_length
	localparam int LENGTH_BITS     = 11;
	localparam int OUT_LENGTH_BITS = 11;
	// Room for 16 + 4 * count and for the counter itself
	localparam int SIZE_BITS       = LENGTH_BITS + 1;

	localparam logic [LENGTH_BITS-1:0] INDEX_MAX = {LENGTH_BITS{1'b1}};

	// Packet layout
	localparam int FIXED_HEADER_BYTES = 8;
	localparam int AUTH_BYTES         = 8;
	localparam int MIN_LENGTH         = FIXED_HEADER_BYTES + AUTH_BYTES;
	localparam int FIELD_BYTES        = 5;

	localparam logic [LENGTH_BITS-1:0] IDX_VER_TYPE   = LENGTH_BITS'(0);
	localparam logic [LENGTH_BITS-1:0] IDX_LAST_FIELD = LENGTH_BITS'(5);
	localparam logic [LENGTH_BITS-1:0] IDX_CKSUM_HI   = LENGTH_BITS'(6);
	localparam logic [LENGTH_BITS-1:0] IDX_CKSUM_LO   = LENGTH_BITS'(7);

	localparam logic [3:0] ADVERT_VERSION = 4'd2;
	localparam logic [3:0] TYPE_ADVERT    = 4'd1;

	// Summary queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TOO_SMALL    = 3'd1,
		ST_BAD_VERSION  = 3'd2,
		ST_BAD_TYPE     = 3'd3,
		ST_BAD_SIZE     = 3'd4,
		ST_BAD_CHECKSUM = 3'd5
	} status_t;

	// Everything the back end needs about one finished packet
	typedef struct packed {
		logic [LENGTH_BITS-1:0]   length;
		logic [7:0]               first_byte;
		logic [8*FIELD_BYTES-1:0] fields;
		logic [15:0]              sum;
		logic [15:0]              recv_sum;
	} summary_t;

endpackage

`default_nettype wire

FILE: design/vac_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vac_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        byte_value,
	input  wire logic              last_byte,
	output logic                   rec_push,
	output vac_pkg::summary_t      rec
);

	logic [vac_pkg::LENGTH_BITS-1:0]     byte_index_q, idx_d;
	logic [15:0]                         running_sum_q, sum_d;
	logic [7:0]                          high_half_q, high_d;
	logic [7:0]                          first_byte_q, first_d;
	logic [8*vac_pkg::FIELD_BYTES-1:0]   fields_q, fields_d;
	logic [15:0]                         recv_q, recv_d;

	logic                                counting;
	logic [vac_pkg::LENGTH_BITS-1:0]     idx_m1;
	logic [vac_pkg::LENGTH_BITS-1:0]     start;
	logic [vac_pkg::SIZE_BITS-1:0]       addr_end;
	logic                                take;
	logic [16:0]                         sum_wide;
	logic [7:0]                          count;

	assign counting = (byte_index_q != vac_pkg::INDEX_MAX);
	assign idx_m1   = byte_index_q - vac_pkg::LENGTH_BITS'(1);
	assign start    = {byte_index_q[vac_pkg::LENGTH_BITS-1:1], 1'b0};
	assign count    = fields_q[23:16];
	assign addr_end = vac_pkg::SIZE_BITS'(vac_pkg::FIXED_HEADER_BYTES)
		+ vac_pkg::SIZE_BITS'({count, 2'b00});
	assign take     = (start < vac_pkg::IDX_CKSUM_HI)
		|| ((vac_pkg::SIZE_BITS'(start) >= vac_pkg::SIZE_BITS'(vac_pkg::FIXED_HEADER_BYTES))
		&& (vac_pkg::SIZE_BITS'(start) < addr_end));
	assign sum_wide = {1'b0, running_sum_q} + {1'b0, high_half_q, byte_value};

	// Absorb the current byte into the next state
	always_comb begin
		idx_d    = byte_index_q;
		sum_d    = running_sum_q;
		high_d   = high_half_q;
		first_d  = first_byte_q;
		fields_d = fields_q;
		recv_d   = recv_q;
		if (counting) begin
			idx_d = byte_index_q + vac_pkg::LENGTH_BITS'(1);
			unique case (byte_index_q)
				vac_pkg::IDX_VER_TYPE: first_d = byte_value;
				vac_pkg::IDX_CKSUM_HI: recv_d[15:8] = byte_value;
				vac_pkg::IDX_CKSUM_LO: recv_d[7:0] = byte_value;
				default: begin
					if (byte_index_q <= vac_pkg::IDX_LAST_FIELD)
						fields_d[{idx_m1[2:0], 3'b000} +: 8] = byte_value;
				end
			endcase
			// Pair bytes into words, fold the end-around carry
			if (!byte_index_q[0]) begin
				high_d = byte_value;
			end else if (take) begin
				sum_d = sum_wide[15:0] + 16'(sum_wide[16]);
			end
		end
	end

	// Hand a finished packet to the queue
	assign rec_push        = accept && last_byte;
	assign rec.length      = idx_d;
	assign rec.first_byte  = first_d;
	assign rec.fields      = fields_d;
	assign rec.sum         = sum_d;
	assign rec.recv_sum    = recv_d;

	// Advance on every beat, clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			running_sum_q <= '0;
			high_half_q   <= '0;
			first_byte_q  <= '0;
			fields_q      <= '0;
			recv_q        <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_index_q  <= '0;
				running_sum_q <= '0;
				high_half_q   <= '0;
				first_byte_q  <= '0;
				fields_q      <= '0;
				recv_q        <= '0;
			end else begin
				byte_index_q  <= idx_d;
				running_sum_q <= sum_d;
				high_half_q   <= high_d;
				first_byte_q  <= first_d;
				fields_q      <= fields_d;
				recv_q        <= recv_d;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/vac_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vac_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  vac_pkg::summary_t      push_data,
	output logic                   full,
	input  wire logic              pop,
	output vac_pkg::summary_t      pop_data,
	output logic                   empty
);

	vac_pkg::summary_t                  slots_q [vac_pkg::QUEUE_DEPTH];
	logic [vac_pkg::QPTR_BITS-1:0]      wr_ptr_q, rd_ptr_q;
	logic [vac_pkg::QCNT_BITS-1:0]      count_q;
	logic                               do_push, do_pop;

	assign full     = (count_q == vac_pkg::QCNT_BITS'(vac_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slots_q[rd_ptr_q];

	// Store the summary of a finished packet
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == vac_pkg::QPTR_BITS'(vac_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + vac_pkg::QPTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == vac_pkg::QPTR_BITS'(vac_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + vac_pkg::QPTR_BITS'(1);
			if (do_push && !do_pop)
				count_q <= count_q + vac_pkg::QCNT_BITS'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - vac_pkg::QCNT_BITS'(1);
		end
	end

endmodule

`default_nettype wire

FILE: design/vac_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vac_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  vac_pkg::summary_t                        q_data,
	output logic                                     q_pop,
	output logic [2:0]                               status,
	output logic [7:0]                               router_id,
	output logic [7:0]                               priority_res,
	output logic [7:0]                               address_count,
	output logic [7:0]                               auth_kind,
	output logic [7:0]                               advert_interval,
	output logic [vac_pkg::OUT_LENGTH_BITS-1:0]      packet_length,
	output logic                                     empty,
	input  wire logic                                pop
);

	logic                            valid_q;
	logic                            load;
	vac_pkg::status_t                status_d;
	vac_pkg::status_t                status_q;
	logic [7:0]                      count;
	logic [vac_pkg::SIZE_BITS-1:0]   length_w, expect_len;
	logic [15:0]                     check;
	logic [7:0]                      router_q, prio_q, count_q, auth_q, interval_q;
	logic [vac_pkg::OUT_LENGTH_BITS-1:0] length_q;

	assign count      = q_data.fields[23:16];
	assign length_w   = vac_pkg::SIZE_BITS'(q_data.length);
	assign expect_len = vac_pkg::SIZE_BITS'(vac_pkg::MIN_LENGTH)
		+ vac_pkg::SIZE_BITS'({count, 2'b00});
	assign check      = ~q_data.sum;

	// Run the checks in priority order
	always_comb begin
		if (length_w < vac_pkg::SIZE_BITS'(vac_pkg::MIN_LENGTH))
			status_d = vac_pkg::ST_TOO_SMALL;
		else if (q_data.first_byte[7:4] != vac_pkg::ADVERT_VERSION)
			status_d = vac_pkg::ST_BAD_VERSION;
		else if (q_data.first_byte[3:0] != vac_pkg::TYPE_ADVERT)
			status_d = vac_pkg::ST_BAD_TYPE;
		else if (length_w != expect_len)
			status_d = vac_pkg::ST_BAD_SIZE;
		else if (check != q_data.recv_sum)
			status_d = vac_pkg::ST_BAD_CHECKSUM;
		else
			status_d = vac_pkg::ST_OK;
	end

	// Refill the result register when it is empty or being taken
	assign load  = !q_empty && (!valid_q || pop);
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Hold result payload
	always_ff @(posedge clk) begin
		if (load) begin
			status_q   <= status_d;
			router_q   <= q_data.fields[7:0];
			prio_q     <= q_data.fields[15:8];
			count_q    <= count;
			auth_q     <= q_data.fields[31:24];
			interval_q <= q_data.fields[39:32];
			length_q   <= q_data.length[vac_pkg::OUT_LENGTH_BITS-1:0];
		end
	end

	assign empty           = !valid_q;
	assign status          = status_q;
	assign router_id       = router_q;
	assign priority_res    = prio_q;
	assign address_count   = count_q;
	assign auth_kind       = auth_q;
	assign advert_interval = interval_q;
	assign packet_length   = length_q;

endmodule

`default_nettype wire

FILE: design/vrrp_advert_checker_top.sv
// Channel   Handshake        Beat
// input     push / full      byte_value[7:0], last_byte
// result    empty / pop      status[2:0], router_id, priority_res, address_count,
//                            auth_kind, advert_interval, packet_length[10:0]
//
// One byte per cycle while full is low; the front end sums and stores in the cycle it takes the byte.
// At the edge that takes its last byte, a packet's summary enters the queue; the checks
// then load it into the result register once that register is empty or being popped.
// full rises only when the two-entry summary queue holds two finished packets.
// Reset (arst_n low) clears the byte counter, the checksum, the summary queue and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module vrrp_advert_checker_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [7:0]                          byte_value,
	input  wire logic                                last_byte,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [2:0]                               status,
	output logic [7:0]                               router_id,
	output logic [7:0]                               priority_res,
	output logic [7:0]                               address_count,
	output logic [7:0]                               auth_kind,
	output logic [7:0]                               advert_interval,
	output logic [vac_pkg::OUT_LENGTH_BITS-1:0]      packet_length
);

	logic              accept;
	logic              rec_push;
	vac_pkg::summary_t rec;
	logic              q_full, q_empty, q_pop;
	vac_pkg::summary_t q_data;

	assign full   = q_full;
	assign accept = push && !q_full;

	vac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.rec_push   (rec_push),
		.rec        (rec)
	);

	vac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	vac_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (q_data),
		.q_pop           (q_pop),
		.status          (status),
		.router_id       (router_id),
		.priority_res    (priority_res),
		.address_count   (address_count),
		.auth_kind       (auth_kind),
		.advert_interval (advert_interval),
		.packet_length   (packet_length),
		.empty           (empty),
		.pop             (pop)
	);

endmodule

`default_nettype wire

FILE: design/vac_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "vrrp_advert_checker_top_defines.svh"

module vac_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                empty,
	input  wire logic                                pop,
	input  wire logic [2:0]                          status,
	input  wire logic [7:0]                          address_count,
	input  wire logic [vac_pkg::OUT_LENGTH_BITS-1:0] packet_length
);

	// Status code stays within the defined set
	`VAC_ASSERT_NOW(a_status_range, !empty, status <= vac_pkg::ST_BAD_CHECKSUM)

	// A passing packet has exactly the advertised size
	`VAC_ASSERT_NOW(a_ok_size, !empty && status == vac_pkg::ST_OK, 12'(packet_length) == 12'd16 + 12'(address_count) * 12'd4)

	// A short packet really is short
	`VAC_ASSERT_NOW(a_small_len, !empty && status == vac_pkg::ST_TOO_SMALL, packet_length < 11'd16)

	// Hold a waiting result until it is taken
	`VAC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status) && $stable(packet_length))

endmodule

bind vrrp_advert_checker_top vac_checker u_vac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.status        (status),
	.address_count (address_count),
	.packet_length (packet_length)
);

`default_nettype wire
